// ===== src/battery_charge_level_estimator_unit_macros.svh =====
// Assertion macros shared by the charge level estimator RTL.
`ifndef BATTERY_CHARGE_LEVEL_ESTIMATOR_UNIT_MACROS_SVH
`define BATTERY_CHARGE_LEVEL_ESTIMATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define BCLE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define BCLE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/bcle_pkg.sv =====
// Types, constants and arithmetic helpers of the charge level estimator.
package bcle_pkg;

	localparam int FRAC_BITS            = 16;
	localparam int VALUE_ITERATIONS_DEF = 12;
	localparam int ROOT_ITERATIONS_DEF  = 10;
	localparam int HYSTERESIS_BAND      = 5;

	localparam int VW     = 19;  // voltage fields
	localparam int PW     = 24;  // load power
	localparam int ZW     = 23;  // zero point
	localparam int OW     = 7;   // percent
	localparam int XW     = 24;  // search variables (voltages and raw values)
	localparam int UW     = XW - 6;
	localparam int RW     = 28;  // polynomial accumulator
	localparam int YW     = 20;  // polynomial argument
	localparam int MA_W   = 28;
	localparam int MB_W   = 26;
	localparam int PRW    = MA_W + MB_W;
	localparam int IDX_W  = 2;
	localparam int CFG_DW = 23;
	localparam int DW     = 26;  // calibration span
	localparam int NW     = 33;  // scaled numerator
	localparam int TW     = 35;  // rounding dividend

	localparam logic [IDX_W-1:0] REG_EMPTY = 2'd0;
	localparam logic [IDX_W-1:0] REG_FULL  = 2'd1;
	localparam logic [IDX_W-1:0] REG_ZERO  = 2'd2;

	localparam logic [VW-1:0] EMPTY_RST = 19'd196608;
	localparam logic [VW-1:0] FULL_RST  = 19'd275251;
	localparam logic [ZW-1:0] ZERO_RST  = 23'd0;

	localparam int RECIP_SHIFT = 31;
	localparam logic signed [MB_W-1:0] RECIP_100 = 26'sd21474836;

	localparam logic [XW-1:0] Q_RAW_TOP  = XW'(125 << FRAC_BITS);
	localparam logic [XW-1:0] Q_THREE_V  = XW'(3 << FRAC_BITS);
	localparam logic signed [XW:0] Q_THREE = (XW+1)'(3 << FRAC_BITS);
	localparam logic signed [XW:0] Q_FOUR  = (XW+1)'(4 << FRAC_BITS);
	localparam logic signed [XW:0] Q_MFOUR = -Q_FOUR;
	localparam logic signed [PRW-1:0] Q_HALF    = PRW'(64'(1) << (FRAC_BITS - 1));
	localparam logic signed [PRW-1:0] Q_HALF_M1 = Q_HALF - PRW'(1);

	typedef enum logic [4:0] {
		ST_IDLE, ST_START, ST_MID, ST_DIV_MUL, ST_DIV_FIX, ST_HMUL, ST_HADD,
		ST_POLY_DONE, ST_T_INIT, ST_TM1, ST_TA1, ST_TM2, ST_TA2, ST_TM3, ST_TA3,
		ST_TEST_DONE, ST_END, ST_FINAL, ST_QCHK, ST_QDIV, ST_QEND, ST_HYST
	} state_t;

	typedef enum logic [2:0] {
		PH_FULL, PH_RES3, PH_TOP, PH_SLP_E, PH_SLP_BIS, PH_RES_DZ, PH_RES_BIS, PH_RAW
	} phase_t;

	typedef enum logic [1:0] {PK_CURVE, PK_RES, PK_SLP} poly_t;

	function automatic logic signed [RW-1:0] poly_lead(poly_t kind);
		unique case (kind)
			PK_CURVE: return RW'(-45875);
			PK_RES:   return RW'(45652);
			PK_SLP:   return RW'(182610);
			default:  return '0;
		endcase
	endfunction

	function automatic logic signed [RW-1:0] poly_coef(poly_t kind, logic [1:0] k);
		logic signed [RW-1:0] c;
		c = '0;
		unique case (kind)
			PK_CURVE: begin
				unique case (k)
					2'd0: c = RW'(235930);
					2'd1: c = RW'(-294912);
					2'd2: c = RW'(183501);
					default: c = RW'(196608);
				endcase
			end
			PK_RES: begin
				unique case (k)
					2'd0: c = RW'(-168559);
					2'd1: c = RW'(303432);
					2'd2: c = RW'(-242745);
					default: c = RW'(116523);
				endcase
			end
			PK_SLP: begin
				unique case (k)
					2'd0: c = RW'(-505676);
					2'd1: c = RW'(606863);
					default: c = RW'(-242745);
				endcase
			end
			default: c = '0;
		endcase
		return c;
	endfunction

	// Round a product to nearest at FRAC_BITS, ties away from zero.
	function automatic logic signed [RW-1:0] qround(logic signed [PRW-1:0] p);
		logic signed [PRW-1:0] t;
		t = p[PRW-1] ? p + Q_HALF_M1 : p + Q_HALF;
		return RW'(t >>> FRAC_BITS);
	endfunction

	function automatic logic signed [YW-1:0] offset_clamp(logic [XW-1:0] x);
		logic signed [XW:0] d;
		d = $signed({1'b0, x}) - Q_THREE;
		if (d > Q_FOUR) d = Q_FOUR;
		if (d < Q_MFOUR) d = Q_MFOUR;
		return YW'(d);
	endfunction

endpackage

// ===== src/battery_charge_level_estimator_unit.sv =====
// Battery charge level estimator: bisection searches on one shared multiplier.
// A zero voltage goes straight to the result, and a full point that lands on the zero point
// ends after the first search; otherwise the result follows the bisection steps
// that share one 28x26 multiplier for every polynomial step, sign test and division
// by 100. One transaction at a time; the next input is taken once the result is registered.
// Reset clears the state machine and the last percent and loads the calibration registers with their defaults.
`include "battery_charge_level_estimator_unit_macros.svh"

module battery_charge_level_estimator_unit #(
	parameter int VALUE_ITERATIONS = bcle_pkg::VALUE_ITERATIONS_DEF,
	parameter int ROOT_ITERATIONS  = bcle_pkg::ROOT_ITERATIONS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bcle_pkg::VW-1:0]       load_voltage,
	input  logic [bcle_pkg::PW-1:0]       load_power,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bcle_pkg::OW-1:0]       charge_percent,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bcle_pkg::IDX_W-1:0]    cfg_index,
	input  logic [bcle_pkg::CFG_DW-1:0]   cfg_data
);
	import bcle_pkg::*;

	localparam int ITER_MAX = (VALUE_ITERATIONS > ROOT_ITERATIONS) ?
		VALUE_ITERATIONS : ROOT_ITERATIONS;
	localparam int CNT_W = $clog2(ITER_MAX + 1);
	localparam logic [CNT_W-1:0] VR_LAST   = CNT_W'(VALUE_ITERATIONS - 1);
	localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_ITERATIONS - 1);
	localparam logic [2:0] QDIV_LAST = 3'd6;

	state_t state_q, state_d;
	phase_t phase_q;
	poly_t  kind_q;

	logic [VW-1:0] empty_q, full_q;
	logic [ZW-1:0] zero_q;
	logic [VW-1:0] v_q;
	logic [PW-1:0] p_q;
	logic [XW-1:0] s_q, e_q, m_q, dz_q, tgt_q, c_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0] k_q;
	logic signed [RW-1:0] r_q;
	logic signed [YW-1:0] y_q;
	logic signed [PRW-1:0] prod_q;
	logic signed [PRW-1:0] acc_q;
	logic signed [DW-1:0] den_q;
	logic signed [TW-1:0] t_q;
	logic [DW-1:0] d_q;
	logic [TW-2:0] rem_q, dsh_q;
	logic [OW-1:0] q_q;
	logic [2:0] qc_q;
	logic [OW-1:0] pr_q, last_q, out_q;
	logic out_valid_q;

	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic [XW-1:0] n_c, mid_c, rem100_c;
	logic [UW-1:0] uq_c;
	logic signed [RW-1:0] hadd_c;
	logic k_last, vr_lt, acc_neg, acc_pos, cnt_last, vr_phase, slp_phase;
	logic signed [DW-1:0] den_c, den_abs;
	logic signed [DW-1:0] diff_c;
	logic signed [NW-1:0] num_c, num_f;
	logic signed [TW-1:0] t_c;
	logic out_free, hyst_upd;
	logic [OW:0] band_hi;

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign charge_percent = out_q;

	// Shared datapath terms.
	assign n_c      = m_q + XW'(50);
	assign uq_c     = prod_q[RECIP_SHIFT +: UW];
	assign rem100_c = n_c - XW'(uq_c) * XW'(100);
	assign mid_c    = XW'(({1'b0, s_q} + {1'b0, e_q}) >> 1);
	assign hadd_c   = qround(prod_q) + poly_coef(kind_q, k_q);
	assign k_last   = (kind_q == PK_SLP) ? (k_q == 2'd2) : (k_q == 2'd3);
	assign vr_lt    = r_q < $signed({1'b0, tgt_q});
	assign acc_neg  = acc_q[PRW-1];
	assign acc_pos  = !acc_neg && (acc_q != '0);
	assign vr_phase = (phase_q == PH_FULL) || (phase_q == PH_RAW) || (phase_q == PH_TOP);
	assign slp_phase = (phase_q == PH_SLP_E) || (phase_q == PH_SLP_BIS);
	assign cnt_last = ((phase_q == PH_FULL) || (phase_q == PH_RAW)) ?
		(cnt_q == VR_LAST) : (cnt_q == ROOT_LAST);
	assign den_c    = $signed({2'b0, mid_c}) - $signed({3'b0, zero_q});
	assign diff_c   = $signed({2'b0, c_q}) - $signed({3'b0, zero_q});
	assign num_c    = NW'(diff_c) * $signed(NW'(100));
	assign num_f    = den_q[DW-1] ? -num_c : num_c;
	assign den_abs  = den_q[DW-1] ? -den_q : den_q;
	assign t_c      = (TW'(num_f) <<< 1) + TW'(den_abs);
	assign out_free = !(out_valid_q && out_stall);
	assign band_hi  = {1'b0, last_q} + (OW+1)'(HYSTERESIS_BAND);
	assign hyst_upd = (pr_q < last_q) || ({1'b0, pr_q} >= band_hi);

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_DIV_MUL: begin
				mul_a = $signed({{(MA_W-XW){1'b0}}, n_c});
				mul_b = RECIP_100;
			end
			ST_HMUL: begin
				mul_a = r_q;
				mul_b = MB_W'(y_q);
			end
			ST_TM1: begin
				mul_a = r_q;
				mul_b = $signed({{(MB_W-PW){1'b0}}, p_q});
			end
			ST_TM2: begin
				mul_a = $signed({{(MA_W-VW){1'b0}}, v_q});
				mul_b = $signed({{(MB_W-VW){1'b0}}, v_q});
			end
			ST_TM3: begin
				mul_a = $signed({{(MA_W-XW){1'b0}}, m_q});
				mul_b = $signed({{(MB_W-VW){1'b0}}, v_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (in_valid) state_d = ST_START;
			ST_START:     state_d = (v_q == '0) ? ST_HYST : ST_MID;
			ST_MID:       state_d = vr_phase ? ST_DIV_MUL : ST_T_INIT;
			ST_DIV_MUL:   state_d = ST_DIV_FIX;
			ST_DIV_FIX:   state_d = ST_HMUL;
			ST_HMUL:      state_d = ST_HADD;
			ST_HADD:      state_d = k_last ? ST_POLY_DONE : ST_HMUL;
			ST_POLY_DONE: begin
				if (kind_q != PK_CURVE) begin
					state_d = ST_TM1;
				end else if (phase_q == PH_TOP) begin
					state_d = ST_T_INIT;
				end else begin
					state_d = cnt_last ? ST_END : ST_MID;
				end
			end
			ST_T_INIT:    state_d = ST_HMUL;
			ST_TM1:       state_d = ST_TA1;
			ST_TA1:       state_d = (kind_q == PK_SLP) ? ST_TEST_DONE : ST_TM2;
			ST_TM2:       state_d = ST_TA2;
			ST_TA2:       state_d = ST_TM3;
			ST_TM3:       state_d = ST_TA3;
			ST_TA3:       state_d = ST_TEST_DONE;
			ST_TEST_DONE: begin
				priority case (phase_q)
					PH_RES3:    state_d = acc_neg ? ST_FINAL : ST_DIV_MUL;
					PH_SLP_E:   state_d = acc_neg ? ST_T_INIT : ST_MID;
					PH_RES_DZ:  state_d = ST_MID;
					default:    state_d = cnt_last ? ST_END : ST_MID;
				endcase
			end
			ST_END: begin
				priority case (phase_q)
					PH_FULL:    state_d = (den_c == '0) ? ST_HYST : ST_T_INIT;
					PH_RAW:     state_d = ST_FINAL;
					PH_SLP_BIS: state_d = ST_T_INIT;
					default:    state_d = ST_MID;
				endcase
			end
			ST_FINAL:     state_d = ST_QCHK;
			ST_QCHK: begin
				if (t_q[TW-1] || (t_q >= $signed({2'b0, d_q, 7'b0}))) begin
					state_d = ST_HYST;
				end else begin
					state_d = ST_QDIV;
				end
			end
			ST_QDIV:      state_d = (qc_q == QDIV_LAST) ? ST_QEND : ST_QDIV;
			ST_QEND:      state_d = ST_HYST;
			ST_HYST:      if (out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// Control registers: calibration, last result and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_q     <= EMPTY_RST;
			full_q      <= FULL_RST;
			zero_q      <= ZERO_RST;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_EMPTY: empty_q <= cfg_data[VW-1:0];
					REG_FULL:  full_q  <= cfg_data[VW-1:0];
					REG_ZERO:  zero_q  <= cfg_data[ZW-1:0];
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (state_q == ST_HYST && out_free) begin
				out_valid_q <= 1'b1;
				if (hyst_upd) last_q <= pr_q;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					v_q <= load_voltage;
					p_q <= load_power;
				end
			end
			ST_START: begin
				pr_q    <= '0;
				tgt_q   <= XW'(full_q);
				s_q     <= '0;
				e_q     <= Q_RAW_TOP;
				cnt_q   <= '0;
				phase_q <= PH_FULL;
			end
			ST_MID: begin
				m_q <= mid_c;
			end
			ST_DIV_FIX: begin
				y_q    <= (rem100_c >= XW'(100)) ? YW'(uq_c + UW'(1)) : YW'(uq_c);
				r_q    <= poly_lead(PK_CURVE);
				k_q    <= '0;
				kind_q <= PK_CURVE;
			end
			ST_HADD: begin
				r_q <= hadd_c;
				k_q <= k_q + 2'd1;
			end
			ST_POLY_DONE: begin
				if (kind_q == PK_CURVE) begin
					if (phase_q == PH_TOP) begin
						e_q     <= XW'(r_q);
						m_q     <= XW'(r_q);
						s_q     <= XW'(empty_q);
						phase_q <= PH_SLP_E;
					end else begin
						if (vr_lt) s_q <= m_q;
						else e_q <= m_q;
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
			end
			ST_T_INIT: begin
				y_q    <= offset_clamp(m_q);
				kind_q <= slp_phase ? PK_SLP : PK_RES;
				r_q    <= poly_lead(slp_phase ? PK_SLP : PK_RES);
				k_q    <= '0;
			end
			ST_TA1: begin
				if (kind_q == PK_SLP) begin
					acc_q <= prod_q - $signed({{(PRW-VW-FRAC_BITS){1'b0}}, v_q,
						{FRAC_BITS{1'b0}}});
				end else begin
					acc_q <= prod_q;
				end
			end
			ST_TA2: acc_q <= acc_q + prod_q;
			ST_TA3: acc_q <= acc_q - prod_q;
			ST_TEST_DONE: begin
				priority case (phase_q)
					PH_RES3: begin
						c_q     <= '0;
						m_q     <= Q_RAW_TOP;
						phase_q <= PH_TOP;
					end
					PH_SLP_E: begin
						cnt_q <= '0;
						if (acc_neg) begin
							dz_q    <= e_q;
							m_q     <= e_q;
							phase_q <= PH_RES_DZ;
						end else begin
							phase_q <= PH_SLP_BIS;
						end
					end
					PH_SLP_BIS: begin
						if (acc_neg) s_q <= m_q;
						else e_q <= m_q;
						cnt_q <= cnt_q + CNT_W'(1);
					end
					PH_RES_DZ: begin
						cnt_q <= '0;
						if (acc_pos) begin
							tgt_q   <= dz_q;
							s_q     <= '0;
							e_q     <= Q_RAW_TOP;
							phase_q <= PH_RAW;
						end else begin
							s_q     <= XW'(empty_q);
							e_q     <= dz_q;
							phase_q <= PH_RES_BIS;
						end
					end
					default: begin
						if (acc_neg) e_q <= m_q;
						else s_q <= m_q;
						cnt_q <= cnt_q + CNT_W'(1);
					end
				endcase
			end
			ST_END: begin
				priority case (phase_q)
					PH_FULL: begin
						den_q   <= den_c;
						pr_q    <= '0;
						m_q     <= Q_THREE_V;
						phase_q <= PH_RES3;
					end
					PH_RAW: c_q <= mid_c;
					PH_SLP_BIS: begin
						dz_q    <= mid_c;
						m_q     <= mid_c;
						phase_q <= PH_RES_DZ;
					end
					default: begin
						tgt_q   <= mid_c;
						s_q     <= '0;
						e_q     <= Q_RAW_TOP;
						cnt_q   <= '0;
						phase_q <= PH_RAW;
					end
				endcase
			end
			ST_FINAL: begin
				t_q <= t_c;
				d_q <= DW'({den_abs[DW-2:0], 1'b0});
			end
			ST_QCHK: begin
				pr_q  <= t_q[TW-1] ? OW'(0) : OW'(100);
				rem_q <= t_q[TW-2:0];
				dsh_q <= (TW-1)'({d_q, 6'b0});
				q_q   <= '0;
				qc_q  <= '0;
			end
			ST_QDIV: begin
				if (rem_q >= dsh_q) begin
					rem_q <= rem_q - dsh_q;
					q_q   <= {q_q[OW-2:0], 1'b1};
				end else begin
					q_q   <= {q_q[OW-2:0], 1'b0};
				end
				dsh_q <= dsh_q >> 1;
				qc_q  <= qc_q + 3'd1;
			end
			ST_QEND: pr_q <= (q_q > OW'(100)) ? OW'(100) : q_q;
			ST_HYST: begin
				if (out_free) out_q <= hyst_upd ? pr_q : last_q;
			end
			default: ;
		endcase
	end

	`BCLE_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
		"block accepted a transaction but did not turn busy")
	`BCLE_ASSERT_IMP(a_result_range, out_valid, charge_percent <= OW'(100),
		"charge percent above 100")
	`BCLE_ASSERT_IMP(a_result_source, $rose(out_valid), $past(state_q) == ST_HYST,
		"result raised outside the hysteresis step")
	`BCLE_ASSERT_IMP(a_count_range, state_q == ST_MID, cnt_q < CNT_W'(ITER_MAX),
		"bisection count ran past its iteration limit")

endmodule
